>>> hw/rtl/cwm_pkg.sv
// Package for the circle wipe row mask block: edge constants and mask types.
// No dependencies; used by cwm_packer and circle_wipe_row_mask_unit.
package cwm_pkg;

    localparam int unsigned NUM_COLS   = 40;
    localparam logic [4:0]  CENTER_COL = 5'd20;
    localparam logic [4:0]  LEFT_START = 5'd21;   // left edge plus one at frame start
    localparam logic [5:0]  RIGHT_START = 6'd20;
    localparam logic [5:0]  LAST_COL   = 6'd39;
    localparam logic [16:0] STEP_ADD   = 17'd49;

    typedef logic [NUM_COLS-1:0] cwm_cols_t;

    // Six playfield register bytes for one row.
    typedef struct packed {
        logic [7:0] left_pf0;
        logic [7:0] left_pf1;
        logic [7:0] left_pf2;
        logic [7:0] right_pf0;
        logic [7:0] right_pf1;
        logic [7:0] right_pf2;
    } cwm_mask_t;

endpackage

>>> hw/rtl/cwm_if.sv
// Valid/ready channel interfaces for the circle wipe row mask block.
// No dependencies.
interface cwm_req_if;
    logic        valid;
    logic        ready;
    logic        first_row;
    logic [15:0] radius_sq;

    modport source (output valid, output first_row, output radius_sq, input ready);
    modport sink   (input valid, input first_row, input radius_sq, output ready);
endinterface

interface cwm_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] row_top;
    logic [7:0] row_bottom;
    logic [7:0] mask_left_pf0;
    logic [7:0] mask_left_pf1;
    logic [7:0] mask_left_pf2;
    logic [7:0] mask_right_pf0;
    logic [7:0] mask_right_pf1;
    logic [7:0] mask_right_pf2;
    logic       last_row;

    modport source (
        output valid, output row_top, output row_bottom,
        output mask_left_pf0, output mask_left_pf1, output mask_left_pf2,
        output mask_right_pf0, output mask_right_pf1, output mask_right_pf2,
        output last_row, input ready
    );
    modport sink (
        input valid, input row_top, input row_bottom,
        input mask_left_pf0, input mask_left_pf1, input mask_left_pf2,
        input mask_right_pf0, input mask_right_pf1, input mask_right_pf2,
        input last_row, output ready
    );
endinterface

>>> hw/rtl/cwm_packer.sv
// Packs the 40 column bits into playfield register byte order.
// Depends on cwm_pkg.
module cwm_packer
    import cwm_pkg::*;
(
    input  cwm_cols_t cols,
    output cwm_mask_t mask
);

    always_comb
    begin
        mask = '0;
        for (int i = 0; i < 4; i++)
        begin
            mask.left_pf0[4+i]  = cols[i];
            mask.right_pf0[4+i] = cols[20+i];
        end
        for (int i = 0; i < 8; i++)
        begin
            // PF1 is reversed, PF2 is straight
            mask.left_pf1[7-i]  = cols[4+i];
            mask.right_pf1[7-i] = cols[24+i];
            mask.left_pf2[i]    = cols[12+i];
            mask.right_pf2[i]   = cols[32+i];
        end
    end

endmodule

>>> hw/rtl/circle_wipe_row_mask_unit.sv
// Top level of the circle wipe row mask block: sequencer, shared squarer, widen loop.
// Depends on cwm_pkg, cwm_if (cwm_req_if, cwm_rsp_if) and cwm_packer.
//
// Usage:
//   req carries one beat per scanline: first_row restarts the frame (column bits
//   cleared, edges back to column 20, row zero), radius_sq is the squared radius.
//   rsp returns one beat per req beat: row index, mirrored bottom row, six mask
//   bytes in playfield order and a flag on the last row above the center.
// Sequence:
//   A beat passes from acceptance through ST_SQ_DX and ST_SQ_DY on one shared
//   8x8 squarer for the row distance, then through the widen loop, one edge step
//   per cycle through a single add/compare for n edge widening steps (0..21), and
//   last through ST_DONE into the output register.
//   req.ready is high only in idle, so a new beat is taken only once the last is done.
// Output:
//   Results sit in an output register; a new req beat is taken while a result
//   still waits. If the receiver stalls, a finished row holds in the sequencer
//   until the output register frees up.
// Reset:
//   rst_n clears the column bits and row counter, sets the edges back to column 20 and empties the output.
module circle_wipe_row_mask_unit
    import cwm_pkg::*;
#(
    parameter int ARENA_ROWS = 192
)
(
    input logic      clk,
    input logic      rst_n,
    cwm_req_if.sink  req,
    cwm_rsp_if.source rsp
);

    localparam int CENTER = ARENA_ROWS / 2;
    localparam logic [7:0] CENTER_V  = 8'(CENTER);
    localparam logic [6:0] LAST_V    = 7'(CENTER - 1);
    localparam logic [8:0] ROWS_M1_V = 9'(ARENA_ROWS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_DX,   // dist = dx^2
        ST_SQ_DY,   // dist += dy^2
        ST_WIDEN,   // one edge step per cycle
        ST_DONE     // wait for output register
    } state_t;

    state_t      state_reg, state_next;
    cwm_cols_t   cols_reg, cols_next;
    logic [4:0]  lep1_reg, lep1_next;     // left edge plus one
    logic [5:0]  redge_reg, redge_next;
    logic [6:0]  rowcnt_reg, rowcnt_next;
    logic [6:0]  row_reg, row_next;
    logic [15:0] r2_reg, r2_next;
    logic [16:0] dist_reg, dist_next;
    logic [7:0]  sq_op_reg, sq_op_next;   // squarer operand

    logic        out_valid_reg, out_valid_next;
    logic [6:0]  out_row_reg, out_row_next;
    logic [7:0]  out_bot_reg, out_bot_next;
    cwm_mask_t   out_mask_reg, out_mask_next;
    logic        out_last_reg, out_last_next;

    logic        req_fire;
    logic        out_free;
    logic [15:0] sq;
    logic [4:0]  lep1_eff;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic        widen;
    logic [5:0]  left_idx;
    cwm_mask_t   packed_mask;
    logic [8:0]  bot_full;

    cwm_packer u_packer (
        .cols (cols_reg),
        .mask (packed_mask)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Shared squarer
    assign sq = sq_op_reg * sq_op_reg;

    assign lep1_eff = req.first_row ? LEFT_START : lep1_reg;
    assign dx       = 8'(5'(LEFT_START - lep1_eff)) * 8'd7;
    assign dy       = CENTER_V - {1'b0, row_reg};
    assign widen    = ({1'b0, dist_reg} < {2'b00, r2_reg}) && (lep1_reg != 5'd0);
    assign left_idx = {1'b0, lep1_reg - 5'd1};
    assign bot_full = ROWS_M1_V - {2'b00, row_reg};

    always_comb
    begin
        state_next     = state_reg;
        cols_next      = cols_reg;
        lep1_next      = lep1_reg;
        redge_next     = redge_reg;
        rowcnt_next    = rowcnt_reg;
        row_next       = row_reg;
        r2_next        = r2_reg;
        dist_next      = dist_reg;
        sq_op_next     = sq_op_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_row_next   = out_row_reg;
        out_bot_next   = out_bot_reg;
        out_mask_next  = out_mask_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.first_row)
                    begin
                        cols_next  = '0;
                        lep1_next  = LEFT_START;
                        redge_next = RIGHT_START;
                        row_next   = '0;
                    end
                    else
                    begin
                        row_next = rowcnt_reg;
                    end
                    r2_next    = req.radius_sq;
                    sq_op_next = dx;
                    state_next = ST_SQ_DX;
                end
            end
            ST_SQ_DX:
            begin
                dist_next  = {1'b0, sq};
                sq_op_next = dy;
                state_next = ST_SQ_DY;
            end
            ST_SQ_DY:
            begin
                dist_next  = dist_reg + {1'b0, sq};
                state_next = ST_WIDEN;
            end
            ST_WIDEN:
            begin
                if (widen)
                begin
                    cols_next = cols_reg | (cwm_cols_t'(1) << left_idx)
                                         | (cwm_cols_t'(1) << redge_reg);
                    lep1_next = lep1_reg - 5'd1;
                    if (redge_reg < LAST_COL)
                        redge_next = redge_reg + 6'd1;
                    dist_next = dist_reg + STEP_ADD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_bot_next   = bot_full[7:0];
                    out_mask_next  = packed_mask;
                    out_last_next  = (row_reg >= LAST_V);
                    // Row counter holds on the last row until a restart
                    rowcnt_next    = (row_reg < LAST_V) ? row_reg + 7'd1 : LAST_V;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cols_reg      <= '0;
            lep1_reg      <= LEFT_START;
            redge_reg     <= RIGHT_START;
            rowcnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_reg      <= cols_next;
            lep1_reg      <= lep1_next;
            redge_reg     <= redge_next;
            rowcnt_reg    <= rowcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        r2_reg       <= r2_next;
        dist_reg     <= dist_next;
        sq_op_reg    <= sq_op_next;
        out_row_reg  <= out_row_next;
        out_bot_reg  <= out_bot_next;
        out_mask_reg <= out_mask_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.row_top        = out_row_reg;
    assign rsp.row_bottom     = out_bot_reg;
    assign rsp.mask_left_pf0  = out_mask_reg.left_pf0;
    assign rsp.mask_left_pf1  = out_mask_reg.left_pf1;
    assign rsp.mask_left_pf2  = out_mask_reg.left_pf2;
    assign rsp.mask_right_pf0 = out_mask_reg.right_pf0;
    assign rsp.mask_right_pf1 = out_mask_reg.right_pf1;
    assign rsp.mask_right_pf2 = out_mask_reg.right_pf2;
    assign rsp.last_row       = out_last_reg;

endmodule

>>> sim/tb_circle_wipe_row_mask_unit.sv
// Self-checking testbench for circle_wipe_row_mask_unit: random row beats in,
// checked mask beats out.
// Depends on cwm_pkg, cwm_if (cwm_req_if, cwm_rsp_if) and the block's RTL.
module tb_circle_wipe_row_mask_unit;
    import cwm_pkg::*;

    // Playfield geometry. The block runs with its default height.
    localparam int          ARENA_ROWS = 192;
    localparam int unsigned CENTER_ROW = ARENA_ROWS / 2;
    localparam int unsigned LAST_ROW   = CENTER_ROW - 1;
    localparam int unsigned COL_PITCH  = 7;       // scaled width of one column
    localparam int unsigned MAX_RADIUS = 65025;

    // Watchdog: cycles in a row with no beat on either channel. The worst
    // honest case is the longest sender gap, a row with full widening and a long
    // receiver stall, so this leaves a wide margin.
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned DRAIN_WAIT = 40;      // cycles after the last result

    // One result beat as the block should return it.
    typedef struct packed {
        logic [6:0] row_top;
        logic [7:0] row_bottom;
        cwm_mask_t  masks;
        logic       last_row;
    } row_result_t;

    logic clk;
    logic rst_n;

    cwm_req_if req_ch ();
    cwm_rsp_if rsp_ch ();

    circle_wipe_row_mask_unit #(
        .ARENA_ROWS (ARENA_ROWS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the block's wipe state.
    cwm_cols_t  wipe_cols;
    logic [4:0] left_plus1;      // left edge column plus one, 0 once past column 0
    logic [5:0] right_col;
    logic [6:0] next_row;

    row_result_t expected_rows [$];
    int unsigned fail_count;
    int unsigned burst_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Row predictor: applies one accepted beat to the mirrored state and
    // returns the row's mask beat.
    // ------------------------------------------------------------------
    function automatic row_result_t predict_row(input logic first, input logic [15:0] r2);
        row_result_t res;
        int unsigned row;
        int unsigned dx;
        int unsigned dy;
        int unsigned dist_acc;
        cwm_cols_t   c;

        if (first)
        begin
            wipe_cols  = '0;
            left_plus1 = LEFT_START;
            right_col  = RIGHT_START;
            next_row   = '0;
        end

        row      = next_row;
        dx       = COL_PITCH * (int'(LEFT_START) - int'(left_plus1));
        dy       = (CENTER_ROW >= row) ? CENTER_ROW - row : row - CENTER_ROW;
        dist_acc = dx * dx + dy * dy;

        // Widen until the circle edge is reached or the left edge runs off
        // column 0. The right edge sticks at column 39 on the last step.
        for (int g = 0; g <= int'(CENTER_COL); g++)
        begin
            if (!(dist_acc < r2 && left_plus1 >= 1))
                break;
            wipe_cols[left_plus1 - 1] = 1'b1;
            wipe_cols[right_col]      = 1'b1;
            left_plus1                = left_plus1 - 1;
            if (right_col < LAST_COL)
                right_col = right_col + 1;
            dist_acc += STEP_ADD;
        end

        // Playfield order: PF0 columns in bits 4..7, PF1 reversed, PF2 straight.
        c   = wipe_cols;
        res = '0;
        for (int i = 0; i < 4; i++)
        begin
            res.masks.left_pf0[4 + i]  = c[i];
            res.masks.right_pf0[4 + i] = c[CENTER_COL + i];
        end
        for (int i = 0; i < 8; i++)
        begin
            res.masks.left_pf1[7 - i]  = c[4 + i];
            res.masks.left_pf2[i]      = c[12 + i];
            res.masks.right_pf1[7 - i] = c[CENTER_COL + 4 + i];
            res.masks.right_pf2[i]     = c[CENTER_COL + 12 + i];
        end

        res.row_top    = row[6:0];
        res.row_bottom = 8'(ARENA_ROWS - 1 - row);
        res.last_row   = (row >= LAST_ROW);

        // Past the center the row counter holds on the last row.
        next_row = (row < LAST_ROW) ? 7'(row + 1) : 7'(LAST_ROW);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one request beat per call. Valid stays high across a burst;
    // at the end of a burst it drops for a random gap.
    // ------------------------------------------------------------------
    task automatic send_row(input logic first, input logic [15:0] r2);
        int unsigned gap;

        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.first_row <= first;
        req_ch.radius_sq <= r2;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_rows.push_back(predict_row(first, r2));

        burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
            @(negedge clk);
            req_ch.valid     <= 1'b0;
            req_ch.first_row <= 1'($urandom);
            req_ch.radius_sq <= 16'($urandom);
            repeat (gap - 1) @(negedge clk);
            // Long bursts give stretches with no sender idling at all.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed: radius zero out of reset, exact threshold, full fill with
    // right edge saturation, restart in mid-frame.
    // ------------------------------------------------------------------
    task automatic test_radius_edges();
        send_row(1'b0, 16'd0);         // reset state, radius zero: nothing set
        send_row(1'b0, 16'd9216);      // row 1, dy^2 = 9025: a few steps
        send_row(1'b0, 16'd0);         // masks hold
        send_row(1'b1, 16'd9216);      // row 0, dist equals radius: no step
        send_row(1'b1, 16'd9217);      // one step, just inside
        send_row(1'b1, 16'(MAX_RADIUS)); // all 21 steps, right edge sticks at 39
        send_row(1'b0, 16'(MAX_RADIUS)); // left edge exhausted, no change
        send_row(1'b1, 16'h01fe);      // low radius bits
        send_row(1'b0, 16'd12000);
        send_row(1'b0, 16'd20000);
        send_row(1'b1, 16'd30000);     // restart in mid-frame
        send_row(1'b0, 16'hfe01);
    endtask

    // Well-formed frames: first-row beat, then rows down to the center and up to
    // three past it. Radius shapes: flat, growing per row, random per row, band.
    task automatic test_frames(input int unsigned n_frames);
        int unsigned shape;
        int unsigned base;
        int unsigned slope;
        int unsigned extra;
        int unsigned t;

        for (int unsigned f = 0; f < n_frames; f++)
        begin
            shape = $urandom_range(0, 3);
            base  = $urandom_range(0, 34000);
            slope = $urandom_range(0, 400);
            extra = $urandom_range(0, 3);
            for (int unsigned row = 0; row <= LAST_ROW + extra; row++)
            begin
                case (shape)
                    0: t = base;
                    1: t = base / 4 + row * slope;
                    2: t = $urandom_range(0, MAX_RADIUS);
                    default: t = $urandom_range(8000, 20000);
                endcase
                if (t > MAX_RADIUS)
                    t = MAX_RADIUS;
                send_row(row == 0, 16'(t));
            end
        end
    endtask

    // One frame run well past the center row, with radius zero, full or a ramp per row.
    task automatic test_past_center();
        int unsigned t;

        for (int unsigned row = 0; row <= LAST_ROW + 8; row++)
        begin
            case ($urandom_range(0, 3))
                0: t = 0;
                1: t = MAX_RADIUS;
                default: t = 9000 + row * 120;
            endcase
            send_row(row == 0, 16'(t));
        end
    endtask

    // Broken frames: restarts at random rows, any radius in range.
    task automatic test_noise(input int unsigned n_rows);
        for (int unsigned i = 0; i < n_rows; i++)
            send_row($urandom_range(0, 7) == 0, 16'($urandom_range(0, MAX_RADIUS)));
    endtask

    // ------------------------------------------------------------------
    // Result checker: every rsp beat against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s expected 0x%0h got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        row_result_t exp;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("result beat with no row pending, row_top %0d", rsp_ch.row_top);
                fail_count++;
            end
            else
            begin
                exp = expected_rows.pop_front();
                check_field("row_top", exp.row_top, rsp_ch.row_top);
                check_field("row_bottom", exp.row_bottom, rsp_ch.row_bottom);
                check_field("mask_left_pf0", exp.masks.left_pf0, rsp_ch.mask_left_pf0);
                check_field("mask_left_pf1", exp.masks.left_pf1, rsp_ch.mask_left_pf1);
                check_field("mask_left_pf2", exp.masks.left_pf2, rsp_ch.mask_left_pf2);
                check_field("mask_right_pf0", exp.masks.right_pf0, rsp_ch.mask_right_pf0);
                check_field("mask_right_pf1", exp.masks.right_pf1, rsp_ch.mask_right_pf1);
                check_field("mask_right_pf2", exp.masks.right_pf2, rsp_ch.mask_right_pf2);
                check_field("last_row", exp.last_row, rsp_ch.last_row);
            end
        end
    end

    // Receiver back-pressure: segments of always-ready, light stalls and
    // heavy stalls, each of random length.
    initial
    begin
        int unsigned mode;
        int unsigned seg_len;

        rsp_ch.ready = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(20, 200);
            repeat (seg_len)
            begin
                @(negedge clk);
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when neither channel moves a beat for too long.
    initial
    begin
        int unsigned idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** circle_wipe_row_mask_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.first_row = 1'b0;
        req_ch.radius_sq = '0;
        fail_count       = 0;
        burst_left       = 1;

        // Mirror starts from the block's reset state.
        wipe_cols  = '0;
        left_plus1 = LEFT_START;
        right_col  = RIGHT_START;
        next_row   = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_radius_edges();
        test_frames(7);
        test_past_center();
        test_noise(110);

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Drain: wait for every pending row, then a little longer to catch
        // any stray beat.
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("** circle_wipe_row_mask_unit: PASSED **");
        else
            $display("** circle_wipe_row_mask_unit: FAILED **");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cwm_pkg.sv
hw/rtl/cwm_if.sv
hw/rtl/cwm_packer.sv
hw/rtl/circle_wipe_row_mask_unit.sv
sim/tb_circle_wipe_row_mask_unit.sv
